[src/scfb_pkg.sv]
// ---------------------------------------------------------------------------
// scfb_pkg: shared types and constants for the servo command frame builder
// Frame descriptor, request and configuration types, command codes.
// ---------------------------------------------------------------------------
`default_nettype none

package scfb_pkg;

    // Frame bytes
    localparam logic [7:0] HDR_BYTE      = 8'hFF;
    localparam logic [7:0] BCAST_ID      = 8'hFE;
    localparam logic [7:0] CS_MASK       = 8'hFE;
    localparam logic [7:0] CMD_IJOG      = 8'h05;
    localparam logic [7:0] CMD_RAM_WRITE = 8'h03;
    localparam logic [7:0] CMD_RAM_READ  = 8'h04;
    localparam logic [7:0] JOG_SET       = 8'h04;
    localparam logic [7:0] ADDR_TORQUE   = 8'd52;
    localparam logic [7:0] ADDR_STATUS   = 8'd48;
    localparam logic [11:0] PLAY_MAX_MS  = 12'd2500;

    // Frame sizes and data lengths
    localparam logic [7:0] SIZE_JOG    = 8'd12;
    localparam logic [7:0] SIZE_TORQUE = 8'd10;
    localparam logic [7:0] SIZE_CLEAR  = 8'd11;
    localparam logic [7:0] SIZE_READ   = 8'd9;
    localparam logic [2:0] ND_JOG      = 3'd5;
    localparam logic [2:0] ND_TORQUE   = 3'd3;
    localparam logic [2:0] ND_CLEAR    = 3'd4;
    localparam logic [2:0] ND_READ     = 3'd2;

    // Shared divider geometry
    localparam int DIV_NW = 20;
    localparam int DIV_DW = 10;
    localparam int DIV_CW = $clog2(DIV_NW);

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int PADDR_W = 5;

    // Configuration register reset values
    localparam logic [9:0] MIN_TICKS_RST = 10'd100;
    localparam logic [9:0] MAX_TICKS_RST = 10'd900;
    localparam logic [9:0] ANGLE_RST     = 10'd150;
    localparam logic [9:0] TC_RST        = 10'd112;
    localparam logic [7:0] MODE_ON_RST   = 8'h60;

    typedef enum logic [2:0] {
        REG_MIN_TICKS = 3'd0,
        REG_MAX_TICKS = 3'd1,
        REG_ANGLE     = 3'd2,
        REG_TC        = 3'd3,
        REG_MODE_ON   = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        REQ_JOG    = 2'd0,
        REQ_TORQUE = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_READ   = 2'd3
    } t_req_type;

    typedef struct packed {
        logic [9:0] min_ticks;
        logic [9:0] max_ticks;
        logic [9:0] angle_range;
        logic [9:0] time_constant_tenths;
        logic [7:0] mode_on;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        arm;
        logic [15:0] target_position;
        logic [15:0] play_time_ms;
        logic [7:0]  left_mode;
        logic [7:0]  right_mode;
        logic [7:0]  servo_id;
        logic [7:0]  ram_address;
        logic [1:0]  read_length;
    } t_req;

    // One frame as handed from front end to serializer
    typedef struct packed {
        logic [7:0]      size;
        logic [7:0]      id;
        logic [7:0]      cmd;
        logic [7:0]      cs;
        logic [2:0]      nd;
        logic [4:0][7:0] data;
        logic            fin;
    } t_frame;

endpackage

`default_nettype wire

[src/scfb_div.sv]
// ---------------------------------------------------------------------------
// scfb_div: restoring divider, one quotient bit per cycle
// Unsigned DIV_NW-bit dividend by DIV_DW-bit divisor.
// ---------------------------------------------------------------------------
`default_nettype none

module scfb_div
    import scfb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIV_NW-1:0] i_dividend,
    input  wire logic [DIV_DW-1:0] i_divisor,
    output logic                   o_done,
    output logic [DIV_NW-1:0]      o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_NW-1:0] r_quot;
    logic [DIV_DW-1:0] r_div;

    logic [DIV_DW:0]   rem_sh;
    logic [DIV_DW:0]   rem_diff;
    logic              n_bit;
    logic [DIV_DW-1:0] n_rem;

    always_comb begin
        rem_sh   = {r_rem, r_quot[DIV_NW-1]};
        rem_diff = rem_sh - {1'b0, r_div};
        n_bit    = (rem_sh >= {1'b0, r_div});
        n_rem    = n_bit ? rem_diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[DIV_NW-2:0], n_bit};
            if (r_cnt == DIV_CW'(DIV_NW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

[src/scfb_front.sv]
// ---------------------------------------------------------------------------
// scfb_front: request decoder and frame planner
// Accepts requests, keeps arm state, works out jog ticks and play time,
// and pushes frame descriptors into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module scfb_front
    import scfb_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire logic   i_req_valid,
    output logic        o_req_ready,
    input  wire t_req   i_req,
    output logic        o_push_valid,
    input  wire logic   i_push_ready,
    output t_frame      o_push_frame
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_START,
        S_DIV,
        S_PUSH,
        S_PUSH2
    } t_state;

    t_state      r_state;
    logic [1:0]  r_type;
    logic        r_arm;
    logic [9:0]  r_pos;
    logic [11:0] r_ms;
    logic [7:0]  r_ml;
    logic [7:0]  r_mr;
    logic [7:0]  r_sid;
    logic [7:0]  r_addr;
    logic [1:0]  r_rlen;
    logic        r_neg;
    logic [9:0]  r_abs_span;
    logic [DIV_NW-1:0] r_prod;
    logic [14:0] r_play_num;

    logic [7:0]  r_arm_mode [2];
    logic [9:0]  r_last     [2];
    logic        r_lvalid   [2];

    logic        accept;
    logic [9:0]  pos_in;
    logic        jog_go;
    logic        div_start;
    logic        tick_done;
    logic        play_done;
    logic [DIV_NW-1:0] tick_q;
    logic [DIV_NW-1:0] play_q;
    logic [9:0]  q_mag;
    logic [9:0]  q_signed;
    logic [9:0]  ticks;
    logic [7:0]  play;
    logic [7:0]  t_mode;
    t_frame      frame;

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign div_start   = (r_state == S_START);

    always_comb begin
        pos_in = (i_req.target_position > {6'd0, i_cfg.angle_range}) ?
                 i_cfg.angle_range : i_req.target_position[9:0];
        jog_go = (r_arm_mode[i_req.arm] == i_cfg.mode_on) &&
                 !(r_lvalid[i_req.arm] && (r_last[i_req.arm] == pos_in));
    end

    scfb_div u_div_tick (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (i_cfg.angle_range),
        .o_done     (tick_done),
        .o_quot     (tick_q)
    );

    scfb_div u_div_play (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({{(DIV_NW - 15){1'b0}}, r_play_num}),
        .i_divisor  (i_cfg.time_constant_tenths),
        .o_done     (play_done),
        .o_quot     (play_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_arm_mode[0] <= '0;
            r_arm_mode[1] <= '0;
            r_last[0]   <= '0;
            r_last[1]   <= '0;
            r_lvalid[0] <= 1'b0;
            r_lvalid[1] <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_type <= i_req.req_type;
                        r_arm  <= i_req.arm;
                        r_pos  <= pos_in;
                        r_ms   <= (i_req.play_time_ms > {4'd0, PLAY_MAX_MS}) ?
                                  PLAY_MAX_MS : i_req.play_time_ms[11:0];
                        r_ml   <= i_req.left_mode;
                        r_mr   <= i_req.right_mode;
                        r_sid  <= i_req.servo_id;
                        r_addr <= i_req.ram_address;
                        r_rlen <= i_req.read_length;
                        r_neg  <= (i_cfg.min_ticks > i_cfg.max_ticks);
                        r_abs_span <= (i_cfg.max_ticks >= i_cfg.min_ticks) ?
                                      (i_cfg.max_ticks - i_cfg.min_ticks) :
                                      (i_cfg.min_ticks - i_cfg.max_ticks);
                        case (i_req.req_type)
                            REQ_JOG: begin
                                // drop the request when the arm is off or the target is unchanged
                                if (jog_go) begin
                                    r_last[i_req.arm]   <= pos_in;
                                    r_lvalid[i_req.arm] <= 1'b1;
                                    r_state <= S_MUL;
                                end
                            end
                            REQ_TORQUE: begin
                                r_arm_mode[0] <= i_req.left_mode;
                                r_arm_mode[1] <= i_req.right_mode;
                                if (i_req.left_mode != i_cfg.mode_on) begin
                                    r_lvalid[0] <= 1'b0;
                                end
                                if (i_req.right_mode != i_cfg.mode_on) begin
                                    r_lvalid[1] <= 1'b0;
                                end
                                r_state <= S_PUSH;
                            end
                            default: begin
                                r_state <= S_PUSH;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_prod     <= DIV_NW'(r_abs_span) * DIV_NW'(r_pos);
                    r_play_num <= 15'(r_ms) * 15'd10;
                    r_state    <= S_START;
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (tick_done && play_done) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (i_push_ready) begin
                        if ((r_type == REQ_TORQUE) && (r_ml != r_mr)) begin
                            r_state <= S_PUSH2;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_PUSH2: begin
                    if (i_push_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Jog payload: signed quotient truncates toward zero, so negate the magnitude
    always_comb begin
        q_mag    = (i_cfg.angle_range == '0) ? 10'd0 : tick_q[9:0];
        q_signed = r_neg ? (10'd0 - q_mag) : q_mag;
        ticks    = r_arm ? (i_cfg.max_ticks - q_signed) : (i_cfg.min_ticks + q_signed);
        if ((i_cfg.time_constant_tenths == '0) || (play_q > DIV_NW'(255))) begin
            play = 8'hFF;
        end else begin
            play = play_q[7:0];
        end
        t_mode = (r_state == S_PUSH2) ? r_mr : r_ml;
    end

    always_comb begin
        frame      = '0;
        frame.data = '0;
        case (r_type)
            REQ_JOG: begin
                frame.size    = SIZE_JOG;
                frame.id      = {7'd0, r_arm};
                frame.cmd     = CMD_IJOG;
                frame.nd      = ND_JOG;
                frame.data[0] = ticks[7:0];
                frame.data[1] = {6'd0, ticks[9:8]};
                frame.data[2] = JOG_SET;
                frame.data[3] = {7'd0, r_arm};
                frame.data[4] = play;
                frame.fin     = 1'b1;
            end
            REQ_TORQUE: begin
                frame.size    = SIZE_TORQUE;
                frame.cmd     = CMD_RAM_WRITE;
                frame.nd      = ND_TORQUE;
                frame.data[0] = ADDR_TORQUE;
                frame.data[1] = 8'd1;
                frame.data[2] = t_mode;
                if (r_state == S_PUSH2) begin
                    frame.id  = 8'd1;
                    frame.fin = 1'b1;
                end else if (r_ml == r_mr) begin
                    frame.id  = BCAST_ID;
                    frame.fin = 1'b1;
                end else begin
                    frame.id  = 8'd0;
                    frame.fin = 1'b0;
                end
            end
            REQ_CLEAR: begin
                frame.size    = SIZE_CLEAR;
                frame.id      = r_sid;
                frame.cmd     = CMD_RAM_WRITE;
                frame.nd      = ND_CLEAR;
                frame.data[0] = ADDR_STATUS;
                frame.data[1] = 8'd2;
                frame.fin     = 1'b1;
            end
            default: begin
                frame.size    = SIZE_READ;
                frame.id      = r_sid;
                frame.cmd     = CMD_RAM_READ;
                frame.nd      = ND_READ;
                frame.data[0] = r_addr;
                frame.data[1] = {6'd0, r_rlen};
                frame.fin     = 1'b1;
            end
        endcase
        // unused data bytes are zero, so they drop out of the XOR
        frame.cs = (frame.size ^ frame.id ^ frame.cmd ^ frame.data[0] ^ frame.data[1] ^
                    frame.data[2] ^ frame.data[3] ^ frame.data[4]) & CS_MASK;
    end

    assign o_push_valid = (r_state == S_PUSH) || (r_state == S_PUSH2);
    assign o_push_frame = frame;

endmodule

`default_nettype wire

[src/scfb_queue.sv]
// ---------------------------------------------------------------------------
// scfb_queue: frame descriptor FIFO
// Short queue between the frame planner and the byte serializer.
// ---------------------------------------------------------------------------
`default_nettype none

module scfb_queue
    import scfb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push_valid,
    output logic        o_push_ready,
    input  wire t_frame i_push_frame,
    output logic        o_pop_valid,
    input  wire logic   i_pop_ready,
    output t_frame      o_pop_frame
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_frame        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign do_push      = i_push_valid && o_push_ready;
    assign do_pop       = i_pop_ready && o_pop_valid;
    assign o_pop_frame  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[src/scfb_back.sv]
// ---------------------------------------------------------------------------
// scfb_back: frame byte serializer
// Pops one frame descriptor and sends its bytes through an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module scfb_back
    import scfb_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_pop_valid,
    output logic        o_pop_ready,
    input  wire t_frame i_pop_frame,
    output logic        o_valid,
    input  wire logic   i_ready,
    output logic [7:0]  o_byte,
    output logic        o_first,
    output logic        o_last
);

    t_frame     r_frame;
    logic       r_busy;
    logic [3:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_first;
    logic       r_last;

    logic       slot_free;
    logic       emit;
    logic [3:0] last_idx;
    logic [7:0] n_byte;

    assign o_pop_ready = !r_busy;
    assign slot_free   = !r_valid || i_ready;
    assign emit        = r_busy && slot_free;
    assign last_idx    = 4'd6 + {1'b0, r_frame.nd};

    always_comb begin
        case (r_idx)
            4'd0, 4'd1: n_byte = HDR_BYTE;
            4'd2:       n_byte = r_frame.size;
            4'd3:       n_byte = r_frame.id;
            4'd4:       n_byte = r_frame.cmd;
            4'd5:       n_byte = r_frame.cs;
            4'd6:       n_byte = ~r_frame.cs & CS_MASK;
            4'd7:       n_byte = r_frame.data[0];
            4'd8:       n_byte = r_frame.data[1];
            4'd9:       n_byte = r_frame.data[2];
            4'd10:      n_byte = r_frame.data[3];
            4'd11:      n_byte = r_frame.data[4];
            default:    n_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (!r_busy) begin
                if (i_pop_valid) begin
                    r_frame <= i_pop_frame;
                    r_busy  <= 1'b1;
                    r_idx   <= '0;
                end
            end else if (emit) begin
                if (r_idx == last_idx) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            // advance the output register when it is empty or being taken
            if (slot_free) begin
                r_valid <= emit;
                if (emit) begin
                    r_byte  <= n_byte;
                    r_first <= (r_idx == 4'd0);
                    r_last  <= r_frame.fin && (r_idx == last_idx);
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_first = r_first;
    assign o_last  = r_last;

endmodule

`default_nettype wire

[src/servo_command_frame_builder_unit.sv]
// ---------------------------------------------------------------------------
// servo_command_frame_builder_unit: servo command frame builder, top level
// Turns arm requests into FF FF size id cmd cs1 cs2 data frames, one byte
// per output beat, and holds the APB configuration registers.
// ---------------------------------------------------------------------------
// Each request on the input stream becomes zero, one or two command frames
// of 9 to 12 bytes, sent one byte per beat on the output stream; tuser marks
// the first header byte of every frame and tlast the final byte of the
// request. Each frame is loaded into the serializer and then sent byte by
// byte. A position jog first passes through the front end, where two 20-step
// shift-subtract dividers run side by side for the tick offset and the play
// time; a dropped jog (arm torque off or target unchanged) sends nothing. A
// four-deep frame queue lets the front end take the next request while
// earlier frames are still going out. Write the registers only while no
// request is outstanding.
// ---------------------------------------------------------------------------
`default_nettype none

module servo_command_frame_builder_unit
    import scfb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request stream
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // [0] arm, [16:1] target_position, [32:17] play_time_ms, [40:33] left_mode,
    // [48:41] right_mode, [56:49] servo_id, [64:57] ram_address,
    // [66:65] read_length, [71:67] zero
    input  wire logic [71:0]        s_axis_tdata,
    // [1:0] req_type
    input  wire logic [1:0]         s_axis_tuser,
    // frame byte stream
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // [7:0] tx_byte
    output logic [7:0]              m_axis_tdata,
    // [0] frame_first
    output logic                    m_axis_tuser,
    output logic                    m_axis_tlast,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    t_cfg     r_cfg;
    t_req     req;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    logic     push_valid;
    logic     push_ready;
    t_frame   push_frame;
    logic     pop_valid;
    logic     pop_ready;
    t_frame   pop_frame;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_ticks            <= MIN_TICKS_RST;
            r_cfg.max_ticks            <= MAX_TICKS_RST;
            r_cfg.angle_range          <= ANGLE_RST;
            r_cfg.time_constant_tenths <= TC_RST;
            r_cfg.mode_on              <= MODE_ON_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_MIN_TICKS: r_cfg.min_ticks            <= pwdata[9:0];
                REG_MAX_TICKS: r_cfg.max_ticks            <= pwdata[9:0];
                REG_ANGLE:     r_cfg.angle_range          <= pwdata[9:0];
                REG_TC:        r_cfg.time_constant_tenths <= pwdata[9:0];
                REG_MODE_ON:   r_cfg.mode_on              <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MIN_TICKS: prdata = {22'd0, r_cfg.min_ticks};
            REG_MAX_TICKS: prdata = {22'd0, r_cfg.max_ticks};
            REG_ANGLE:     prdata = {22'd0, r_cfg.angle_range};
            REG_TC:        prdata = {22'd0, r_cfg.time_constant_tenths};
            REG_MODE_ON:   prdata = {24'd0, r_cfg.mode_on};
            default:       prdata = 32'd0;
        endcase
    end

    always_comb begin
        req.req_type        = s_axis_tuser;
        req.arm             = s_axis_tdata[0];
        req.target_position = s_axis_tdata[16:1];
        req.play_time_ms    = s_axis_tdata[32:17];
        req.left_mode       = s_axis_tdata[40:33];
        req.right_mode      = s_axis_tdata[48:41];
        req.servo_id        = s_axis_tdata[56:49];
        req.ram_address     = s_axis_tdata[64:57];
        req.read_length     = s_axis_tdata[66:65];
    end

    scfb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_req_valid  (s_axis_tvalid),
        .o_req_ready  (s_axis_tready),
        .i_req        (req),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_frame (push_frame)
    );

    scfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_frame (push_frame),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_frame  (pop_frame)
    );

    scfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_frame (pop_frame),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_first     (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

endmodule

`default_nettype wire

[tb/servo_command_frame_builder_unit_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// servo_command_frame_builder_unit_test: frame builder testbench
// Streams jog, torque, clear-status and RAM-read requests into the block
// under random idling on both sides. A local frame predictor builds every
// expected byte, and each one is checked as it leaves. Several register
// settings, the extremes among them, are visited between phases.
// ---------------------------------------------------------------------------

module servo_command_frame_builder_unit_test;
    import scfb_pkg::*;

    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 500000;

    typedef struct {
        logic [7:0] tx_byte;
        logic       frame_first;
        logic       last;
    } t_tx_beat;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    // [0] arm, [16:1] target_position, [32:17] play_time_ms, [40:33] left_mode,
    // [48:41] right_mode, [56:49] servo_id, [64:57] ram_address,
    // [66:65] read_length, [71:67] zero
    logic [71:0]         s_axis_tdata;
    // [1:0] req_type
    logic [1:0]          s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // [7:0] tx_byte
    logic [7:0]          m_axis_tdata;
    // [0] frame_first
    logic                m_axis_tuser;
    logic                m_axis_tlast;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // predictor state
    t_cfg                cfg;
    logic [7:0]          arm_torque[2];
    logic [9:0]          arm_last_pos[2];
    logic                arm_pos_held[2];
    t_tx_beat            frame_bytes_due[$];

    int                  mismatches;
    int                  bytes_checked;
    int                  requests_sent;
    int                  directed_requests;
    int                  settings_visited;
    int                  cycle_count;
    int                  source_calm;
    int                  sink_calm;
    int                  sink_gap;
    logic [15:0]         prev_target;
    t_tx_beat            beat;

    servo_command_frame_builder_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Mostly random idling, with occasional runs of back-to-back beats
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
            calm = $urandom_range(5, 30);
        return $urandom_range(0, 17);
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("MISMATCH %s: expected %0h, got %0h (byte %0d)", what, want, got,
                 bytes_checked);
        mismatches++;
    endtask

    function automatic void queue_frame(input logic [7:0] id, input logic [7:0] cmd,
                                        input logic [4:0][7:0] data, input int nd,
                                        input bit fin);
        logic [7:0] size;
        logic [7:0] cs;
        size = 8'(7 + nd);
        cs = size ^ id ^ cmd;
        for (int i = 0; i < nd; i++)
            cs ^= data[i];
        cs &= CS_MASK;
        frame_bytes_due.push_back('{HDR_BYTE, 1'b1, 1'b0});
        frame_bytes_due.push_back('{HDR_BYTE, 1'b0, 1'b0});
        frame_bytes_due.push_back('{size, 1'b0, 1'b0});
        frame_bytes_due.push_back('{id, 1'b0, 1'b0});
        frame_bytes_due.push_back('{cmd, 1'b0, 1'b0});
        frame_bytes_due.push_back('{cs, 1'b0, 1'b0});
        frame_bytes_due.push_back('{~cs & CS_MASK, 1'b0, 1'b0});
        for (int i = 0; i < nd; i++)
            frame_bytes_due.push_back('{data[i], 1'b0, fin && i == nd - 1});
    endfunction

    // Work out the frames one request causes; return how many bytes they hold
    function automatic int predict_frames(input t_req r);
        logic [4:0][7:0] d;
        logic [9:0]      pos;
        int              span;
        int              q;
        int              ticks;
        int unsigned     ms;
        int unsigned     play;
        int              queued_at_entry;
        queued_at_entry = frame_bytes_due.size();
        d = '0;
        case (r.req_type)
            REQ_JOG: begin
                pos = (r.target_position > cfg.angle_range) ? cfg.angle_range
                                                            : r.target_position[9:0];
                if (arm_torque[r.arm] == cfg.mode_on &&
                    !(arm_pos_held[r.arm] && arm_last_pos[r.arm] == pos)) begin
                    span = int'(cfg.max_ticks) - int'(cfg.min_ticks);
                    q = (cfg.angle_range == 0) ? 0
                        : (span * int'(pos)) / int'(cfg.angle_range);
                    ticks = r.arm ? int'(cfg.max_ticks) - q : int'(cfg.min_ticks) + q;
                    ms = (r.play_time_ms > PLAY_MAX_MS) ? PLAY_MAX_MS : r.play_time_ms;
                    play = (cfg.time_constant_tenths == 0) ? 255
                           : (ms * 10) / cfg.time_constant_tenths;
                    if (play > 255)
                        play = 255;
                    d[0] = ticks[7:0];
                    d[1] = ticks[15:8];
                    d[2] = JOG_SET;
                    d[3] = {7'b0, r.arm};
                    d[4] = play[7:0];
                    queue_frame({7'b0, r.arm}, CMD_IJOG, d, ND_JOG, 1'b1);
                    arm_last_pos[r.arm] = pos;
                    arm_pos_held[r.arm] = 1'b1;
                end
            end
            REQ_TORQUE: begin
                arm_torque[0] = r.left_mode;
                arm_torque[1] = r.right_mode;
                if (r.left_mode != cfg.mode_on)
                    arm_pos_held[0] = 1'b0;
                if (r.right_mode != cfg.mode_on)
                    arm_pos_held[1] = 1'b0;
                d[0] = ADDR_TORQUE;
                d[1] = 8'd1;
                d[2] = r.left_mode;
                if (r.left_mode == r.right_mode) begin
                    queue_frame(BCAST_ID, CMD_RAM_WRITE, d, ND_TORQUE, 1'b1);
                end else begin
                    queue_frame(8'd0, CMD_RAM_WRITE, d, ND_TORQUE, 1'b0);
                    d[2] = r.right_mode;
                    queue_frame(8'd1, CMD_RAM_WRITE, d, ND_TORQUE, 1'b1);
                end
            end
            REQ_CLEAR: begin
                d[0] = ADDR_STATUS;
                d[1] = 8'd2;
                queue_frame(r.servo_id, CMD_RAM_WRITE, d, ND_CLEAR, 1'b1);
            end
            default: begin
                d[0] = r.ram_address;
                d[1] = {6'b0, r.read_length};
                queue_frame(r.servo_id, CMD_RAM_READ, d, ND_READ, 1'b1);
            end
        endcase
        return frame_bytes_due.size() - queued_at_entry;
    endfunction

    function automatic t_req random_request();
        t_req r;
        r.req_type        = 2'($urandom_range(0, 3));
        r.arm             = 1'($urandom_range(0, 1));
        r.target_position = 16'($urandom_range(0, 65535));
        r.play_time_ms    = 16'($urandom_range(0, 65535));
        r.left_mode       = 8'($urandom_range(0, 255));
        r.right_mode      = 8'($urandom_range(0, 255));
        r.servo_id        = 8'($urandom_range(0, 255));
        r.ram_address     = 8'($urandom_range(0, 255));
        r.read_length     = 2'($urandom_range(0, 3));
        return r;
    endfunction

    // Present one request, hold it until taken, then predict its frames
    task automatic send_request(input t_req r, inout int productive);
        int gap;
        gap = draw_wait(source_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.req_type;
        s_axis_tdata  <= {5'b0, r.read_length, r.ram_address, r.servo_id, r.right_mode,
                          r.left_mode, r.play_time_ms, r.target_position, r.arm};
        do @(posedge i_clk); while (!s_axis_tready);
        requests_sent++;
        if (predict_frames(r) > 0)
            productive++;
    endtask

    task automatic jog(input logic arm, input logic [15:0] target,
                       input logic [15:0] play_ms);
        t_req r;
        int   dummy;
        r = random_request();
        r.req_type        = REQ_JOG;
        r.arm             = arm;
        r.target_position = target;
        r.play_time_ms    = play_ms;
        send_request(r, dummy);
    endtask

    task automatic torque(input logic [7:0] left, input logic [7:0] right);
        t_req r;
        int   dummy;
        r = random_request();
        r.req_type   = REQ_TORQUE;
        r.left_mode  = left;
        r.right_mode = right;
        send_request(r, dummy);
    endtask

    task automatic status_or_read(input t_req_type kind, input logic [7:0] id,
                                  input logic [7:0] addr, input logic [1:0] len);
        t_req r;
        int   dummy;
        r = random_request();
        r.req_type    = kind;
        r.servo_id    = id;
        r.ram_address = addr;
        r.read_length = len;
        send_request(r, dummy);
    endtask

    // Drain the output, then let the block settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (frame_bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_MIN_TICKS: cfg.min_ticks            = value[9:0];
            REG_MAX_TICKS: cfg.max_ticks            = value[9:0];
            REG_ANGLE:     cfg.angle_range          = value[9:0];
            REG_TC:        cfg.time_constant_tenths = value[9:0];
            default:       cfg.mode_on              = value[7:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(input int min_t, input int max_t, input int angle,
                              input int tc, input int mode);
        wait_idle();
        write_reg(REG_MIN_TICKS, min_t);
        write_reg(REG_MAX_TICKS, max_t);
        write_reg(REG_ANGLE, angle);
        write_reg(REG_TC, tc);
        write_reg(REG_MODE_ON, mode);
        settings_visited++;
    endtask

    // Mostly torque-on followed by jogs, so position frames actually go out
    task automatic run_random_phase(input int quota);
        t_req r;
        int   productive;
        int   kind;
        int   jogs;
        int   sent_at_entry;
        productive = 0;
        sent_at_entry = requests_sent;
        while (requests_sent - sent_at_entry < quota) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                r = random_request();
                r.req_type = REQ_TORQUE;
                if ($urandom_range(0, 3) != 0)
                    r.left_mode = cfg.mode_on;
                if ($urandom_range(0, 3) != 0)
                    r.right_mode = cfg.mode_on;
                send_request(r, productive);
                jogs = $urandom_range(2, 6);
                repeat (jogs) begin
                    r = random_request();
                    r.req_type = REQ_JOG;
                    case ($urandom_range(0, 3))
                        0: r.target_position = 16'($urandom_range(0, cfg.angle_range + 3));
                        1: r.target_position = prev_target;
                        2: r.target_position = {6'd0, cfg.angle_range};
                        default: ;
                    endcase
                    if ($urandom_range(0, 1) == 1)
                        r.play_time_ms = 16'($urandom_range(0, 3000));
                    prev_target = r.target_position;
                    send_request(r, productive);
                end
            end else if (kind <= 7) begin
                r = random_request();
                r.req_type = (kind == 6) ? REQ_CLEAR : REQ_READ;
                send_request(r, productive);
            end else begin
                send_request(random_request(), productive);
            end
        end
    endtask

    task automatic test_jog_basics();
        jog(1'b0, 16'd10, 16'd100);          // torque off: drop
        torque(MODE_ON_RST, MODE_ON_RST);
        jog(1'b0, 16'd0, 16'd0);
        jog(1'b0, 16'd0, 16'd500);           // same target: drop
        jog(1'b1, 16'hFFFF, 16'hFFFF);
        jog(1'b0, 16'd150, 16'd2500);
        jog(1'b1, 16'd75, 16'd2501);
        jog(1'b0, 16'd149, 16'd28);
    endtask

    task automatic test_torque_masking();
        torque(MODE_ON_RST, 8'h00);
        jog(1'b1, 16'd20, 16'd300);          // arm 1 off: drop
        jog(1'b0, 16'd149, 16'd300);         // arm 0 still holds this target: drop
        torque(8'hFF, MODE_ON_RST);
        jog(1'b1, 16'd75, 16'd1000);         // target forgotten while off: send
        torque(8'h00, 8'h00);
    endtask

    task automatic test_status_and_read();
        status_or_read(REQ_CLEAR, 8'h00, 8'h00, 2'd0);
        status_or_read(REQ_CLEAR, 8'hFF, 8'hFF, 2'd3);
        status_or_read(REQ_READ, 8'hFE, 8'h00, 2'd1);
        status_or_read(REQ_READ, 8'h55, 8'hFF, 2'd2);
        status_or_read(REQ_READ, 8'hFF, 8'hAA, 2'd0);
        status_or_read(REQ_READ, 8'h00, 8'h55, 2'd3);
    endtask

    task automatic test_config_sweep();
        set_config(0, 1023, 1023, 1023, 8'hFF);
        run_random_phase(20);
        set_config(1023, 0, 1, 1, 8'h00);    // crossed limits, tiny divisors
        run_random_phase(20);
        set_config($urandom_range(0, 1023), $urandom_range(0, 1023), 0, 0,
                   $urandom_range(0, 255));
        run_random_phase(20);
        set_config($urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(1, 1023), $urandom_range(1, 1023),
                   $urandom_range(0, 255));
        run_random_phase(20);
        set_config(MIN_TICKS_RST, MAX_TICKS_RST, ANGLE_RST, TC_RST, MODE_ON_RST);
        run_random_phase(20);
    endtask

    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            sink_gap = draw_wait(sink_calm);
            if (sink_gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (sink_gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (frame_bytes_due.size() == 0) begin
                report_mismatch("byte with nothing due", 0, m_axis_tdata);
            end else begin
                beat = frame_bytes_due.pop_front();
                if (m_axis_tdata !== beat.tx_byte)
                    report_mismatch("tx_byte", beat.tx_byte, m_axis_tdata);
                if (m_axis_tuser !== beat.frame_first)
                    report_mismatch("frame_first", beat.frame_first, m_axis_tuser);
                if (m_axis_tlast !== beat.last)
                    report_mismatch("last", beat.last, m_axis_tlast);
            end
            bytes_checked++;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        cfg           = '{MIN_TICKS_RST, MAX_TICKS_RST, ANGLE_RST, TC_RST, MODE_ON_RST};
        arm_torque    = '{8'h00, 8'h00};
        arm_last_pos  = '{10'd0, 10'd0};
        arm_pos_held  = '{1'b0, 1'b0};
        mismatches        = 0;
        bytes_checked     = 0;
        requests_sent     = 0;
        settings_visited  = 1;
        cycle_count       = 0;
        source_calm       = 0;
        sink_calm         = 0;
        prev_target       = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_jog_basics();
        test_torque_masking();
        test_status_and_read();
        directed_requests = requests_sent;
        test_config_sweep();
        wait_idle();

        $display("Covered %0d requests (%0d directed) across %0d register settings,",
                 requests_sent, directed_requests, settings_visited);
        $display("with %0d frame bytes checked and %0d mismatches.", bytes_checked,
                 mismatches);
        if (mismatches == 0 && frame_bytes_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
